### sv/miller_rabin_single_base_test_assert.svh
// Assertion macros shared by the primality test modules.
// Needs nothing but the clock and reset names passed in.
`ifndef MILLER_RABIN_SINGLE_BASE_TEST_ASSERT_SVH
`define MILLER_RABIN_SINGLE_BASE_TEST_ASSERT_SVH

// implication checked on every rising clock edge outside reset
`define MR_ASSERT_IMP(label, clk, rstn, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rstn) (lhs) |-> (rhs)) \
        else $error("assertion failed");

// implication whose right side is checked on the next rising clock edge
`define MR_ASSERT_NEXT(label, clk, rstn, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rstn) (lhs) |=> (rhs)) \
        else $error("assertion failed");

`endif

### sv/mrsbt_pkg.sv
// Shared types and command encodings for the primality test.
// No dependencies.
package mrsbt_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SPLIT,
        ST_POW_STEP,
        ST_MUL_WAIT,
        ST_POW_TEST,
        ST_SQ_START,
        ST_SQ_WAIT,
        ST_SQ_TEST,
        ST_DONE
    } state_t;

    // datapath operation selects
    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_SHIFT_D,
        OP_MUL_ACC,
        OP_MUL_BASE,
        OP_MUL_X,
        OP_INIT_X
    } op_t;

    // multiplier operand pairs, sampled when a product is launched
    typedef enum logic [1:0] {
        SEL_BASE_ACC,
        SEL_BASE_SQ,
        SEL_X_SQ
    } mul_sel_t;

    typedef struct packed {
        op_t      op;
        mul_sel_t mul_sel;
        logic     start_mul;
        logic     set_result;
        logic     result_val;
    } cmd_t;

    typedef struct packed {
        logic n_small;     // n <= 3
        logic n_le1;
        logic n_even;
        logic d_odd;
        logic e_gt1;
        logic e_odd;
        logic mul_busy;
        logic x_one;
        logic x_nm1;
        logic s_gt1;
    } status_t;

endpackage

### sv/mrsbt_modmul.sv
// Iterative modular multiplier: (a*b) mod m, one product bit per cycle.
// Uses mrsbt_pkg for nothing; standalone shift-and-subtract reducer.
module mrsbt_modmul #(
    parameter int WIDTH = 32
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [WIDTH-1:0] op_a,
    input  logic [WIDTH-1:0] op_b,
    input  logic [WIDTH-1:0] modulus,
    output logic             busy,
    output logic [WIDTH-1:0] product
);
    localparam int PW = 2 * WIDTH;
    localparam int CW = $clog2(PW + 1);

    logic [PW-1:0]    prod_reg, prod_next;
    logic [WIDTH:0]   rem_reg, rem_next;
    logic [WIDTH-1:0] mod_reg;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic [WIDTH+1:0] shifted;
    logic [WIDTH+1:0] diff;

    always_comb begin
        shifted = {rem_reg, prod_reg[PW-1]};
        diff    = shifted - {2'b00, mod_reg};
    end

    always_comb begin
        prod_next = prod_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            prod_next = PW'(op_a) * PW'(op_b);
            rem_next  = '0;
            cnt_next  = CW'(PW);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            prod_next = {prod_reg[PW-2:0], 1'b0};
            // restoring division step, remainder stays below modulus
            if (!diff[WIDTH+1]) begin
                rem_next = diff[WIDTH:0];
            end else begin
                rem_next = shifted[WIDTH:0];
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        prod_reg <= prod_next;
        rem_reg  <= rem_next;
        if (start) begin
            mod_reg <= modulus;
        end
    end

    assign busy    = busy_reg;
    assign product = rem_reg[WIDTH-1:0];
endmodule

### sv/mrsbt_datapath.sv
// Datapath: operand registers, exponent/shift bookkeeping and the shared multiplier.
// Depends on mrsbt_pkg and mrsbt_modmul.
`include "miller_rabin_single_base_test_assert.svh"

module mrsbt_datapath #(
    parameter int WIDTH = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [WIDTH-1:0]    in_base,
    input  logic [WIDTH-1:0]    in_n,
    input  mrsbt_pkg::cmd_t     cmd,
    output mrsbt_pkg::status_t  status,
    output logic                result
);
    localparam int SW = $clog2(WIDTH + 1);

    logic [WIDTH-1:0] n_reg, e_reg, base_reg, acc_reg, x_reg;
    logic [SW-1:0]    s_reg;
    logic             result_reg;
    logic             mul_busy;
    logic [WIDTH-1:0] mul_a, mul_b, mul_p;
    logic             mul_start;

    always_comb begin
        mul_a = base_reg;
        mul_b = acc_reg;
        case (cmd.mul_sel)
            mrsbt_pkg::SEL_BASE_SQ: mul_b = base_reg;
            mrsbt_pkg::SEL_X_SQ: begin
                mul_a = x_reg;
                mul_b = x_reg;
            end
            default: mul_b = acc_reg;
        endcase
    end
    assign mul_start = cmd.start_mul;

    mrsbt_modmul #(.WIDTH(WIDTH)) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .modulus (n_reg),
        .busy    (mul_busy),
        .product (mul_p)
    );

    always_ff @(posedge aclk) begin
        case (cmd.op)
            mrsbt_pkg::OP_LOAD: begin
                n_reg    <= in_n;
                base_reg <= in_base;
                e_reg    <= in_n - WIDTH'(1);
                acc_reg  <= WIDTH'(1);
                s_reg    <= '0;
            end
            mrsbt_pkg::OP_SHIFT_D: begin
                e_reg <= e_reg >> 1;
                s_reg <= s_reg + SW'(1);
            end
            mrsbt_pkg::OP_MUL_ACC: acc_reg <= mul_p;
            mrsbt_pkg::OP_MUL_BASE: begin
                base_reg <= mul_p;
                e_reg    <= e_reg >> 1;
            end
            mrsbt_pkg::OP_MUL_X: begin
                x_reg <= mul_p;
                s_reg <= s_reg - SW'(1);
            end
            mrsbt_pkg::OP_INIT_X: x_reg <= mul_p;
            default: ;
        endcase
        if (cmd.set_result) begin
            result_reg <= cmd.result_val;
        end
    end

    always_comb begin
        status.n_small  = (in_n <= WIDTH'(3));
        status.n_le1    = (in_n <= WIDTH'(1));
        status.n_even   = ~in_n[0];
        status.d_odd    = e_reg[0];
        status.e_gt1    = (e_reg > WIDTH'(1));
        status.e_odd    = e_reg[0];
        status.mul_busy = mul_busy;
        status.x_one    = (x_reg == WIDTH'(1));
        status.x_nm1    = (x_reg == n_reg - WIDTH'(1));
        status.s_gt1    = (s_reg > SW'(1));
    end

    assign result = result_reg;

    `MR_ASSERT_NEXT(a_mul_busy_after_start, aclk, aresetn, mul_start, mul_busy)
    `MR_ASSERT_IMP(a_no_restart_busy, aclk, aresetn, mul_busy, !mul_start)
    `MR_ASSERT_NEXT(a_shift_counts, aclk, aresetn,
        cmd.op == mrsbt_pkg::OP_SHIFT_D, s_reg != '0)
endmodule

### sv/mrsbt_ctrl.sv
// Controller FSM sequencing special cases, the power ladder and the squaring loop.
// Depends on mrsbt_pkg.
`include "miller_rabin_single_base_test_assert.svh"

module mrsbt_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    input  mrsbt_pkg::status_t status,
    output mrsbt_pkg::cmd_t    cmd
);
    mrsbt_pkg::state_t state_reg, state_next;
    logic              fin_mul_reg, fin_mul_next; // last ladder product pending

    always_comb begin
        state_next   = state_reg;
        fin_mul_next = fin_mul_reg;
        case (state_reg)
            mrsbt_pkg::ST_IDLE:
                // small and even candidates are answered at load
                if (s_valid) begin
                    state_next = (status.n_small || status.n_even) ? mrsbt_pkg::ST_DONE
                                                                   : mrsbt_pkg::ST_CHECK;
                end
            mrsbt_pkg::ST_CHECK:
                state_next = mrsbt_pkg::ST_SPLIT;
            mrsbt_pkg::ST_SPLIT:
                if (status.d_odd) state_next = mrsbt_pkg::ST_POW_STEP;
            mrsbt_pkg::ST_POW_STEP: begin
                fin_mul_next = !status.e_gt1;
                state_next   = mrsbt_pkg::ST_MUL_WAIT;
            end
            mrsbt_pkg::ST_MUL_WAIT:
                if (!status.mul_busy) begin
                    state_next = fin_mul_reg ? mrsbt_pkg::ST_POW_TEST
                                             : mrsbt_pkg::ST_POW_STEP;
                end
            mrsbt_pkg::ST_POW_TEST:
                if (status.x_one || status.x_nm1 || !status.s_gt1) begin
                    state_next = mrsbt_pkg::ST_DONE;
                end else begin
                    state_next = mrsbt_pkg::ST_SQ_START;
                end
            mrsbt_pkg::ST_SQ_START:
                state_next = mrsbt_pkg::ST_SQ_WAIT;
            mrsbt_pkg::ST_SQ_WAIT:
                if (!status.mul_busy) state_next = mrsbt_pkg::ST_SQ_TEST;
            mrsbt_pkg::ST_SQ_TEST:
                if (status.x_one || status.x_nm1 || !status.s_gt1) begin
                    state_next = mrsbt_pkg::ST_DONE;
                end else begin
                    state_next = mrsbt_pkg::ST_SQ_START;
                end
            mrsbt_pkg::ST_DONE:
                if (m_ready) state_next = mrsbt_pkg::ST_IDLE;
            default: state_next = mrsbt_pkg::ST_IDLE;
        endcase
    end

    // Ladder: on ST_POW_STEP with e>1, odd e launches acc*=base first (flag
    // low, returns here), even e launches base*=base. e==1 launches base*acc.
    logic pend_acc_reg, pend_acc_next;

    always_comb begin
        cmd            = '0;
        cmd.op         = mrsbt_pkg::OP_NONE;
        cmd.mul_sel    = mrsbt_pkg::SEL_BASE_ACC;
        s_ready        = 1'b0;
        m_valid        = 1'b0;
        pend_acc_next  = pend_acc_reg;
        case (state_reg)
            mrsbt_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.op         = mrsbt_pkg::OP_LOAD;
                    cmd.set_result = 1'b1;
                    cmd.result_val = 1'b0;
                    if (status.n_small && !status.n_le1) cmd.result_val = 1'b1;
                end
            end
            mrsbt_pkg::ST_SPLIT:
                if (!status.d_odd) cmd.op = mrsbt_pkg::OP_SHIFT_D;
            mrsbt_pkg::ST_POW_STEP: begin
                cmd.start_mul = 1'b1;
                if (!status.e_gt1) begin
                    pend_acc_next = 1'b0;
                end else if (status.e_odd && !pend_acc_reg) begin
                    pend_acc_next = 1'b1;
                end else begin
                    pend_acc_next = 1'b0;
                end
                if (status.e_gt1 && !(status.e_odd && !pend_acc_reg)) begin
                    cmd.mul_sel = mrsbt_pkg::SEL_BASE_SQ;
                end else begin
                    cmd.mul_sel = mrsbt_pkg::SEL_BASE_ACC;
                end
            end
            mrsbt_pkg::ST_MUL_WAIT: ;
            mrsbt_pkg::ST_POW_TEST: begin
                cmd.set_result = 1'b1;
                cmd.result_val = status.x_nm1 || status.x_one;
            end
            mrsbt_pkg::ST_SQ_START: begin
                cmd.start_mul = 1'b1;
                cmd.mul_sel   = mrsbt_pkg::SEL_X_SQ;
            end
            mrsbt_pkg::ST_SQ_TEST: begin
                cmd.set_result = 1'b1;
                cmd.result_val = status.x_nm1 && !status.x_one;
            end
            mrsbt_pkg::ST_DONE: m_valid = 1'b1;
            default: ;
        endcase
        // write back the finished product
        if (state_reg == mrsbt_pkg::ST_MUL_WAIT && !status.mul_busy) begin
            if (fin_mul_reg) cmd.op = mrsbt_pkg::OP_INIT_X;
            else if (pend_acc_reg) cmd.op = mrsbt_pkg::OP_MUL_ACC;
            else cmd.op = mrsbt_pkg::OP_MUL_BASE;
        end
        if (state_reg == mrsbt_pkg::ST_SQ_WAIT && !status.mul_busy) begin
            cmd.op = mrsbt_pkg::OP_MUL_X;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= mrsbt_pkg::ST_IDLE;
            fin_mul_reg  <= 1'b0;
            pend_acc_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            fin_mul_reg  <= fin_mul_next;
            pend_acc_reg <= pend_acc_next;
        end
    end

    `MR_ASSERT_IMP(a_ready_only_idle, aclk, aresetn, s_ready,
        state_reg == mrsbt_pkg::ST_IDLE)
    `MR_ASSERT_IMP(a_valid_not_ready, aclk, aresetn, m_valid, !s_ready)
    `MR_ASSERT_NEXT(a_done_holds, aclk, aresetn, m_valid && !m_ready, m_valid)
endmodule

### sv/miller_rabin_single_base_test.sv
// Strong probable prime test for one base: top level joining controller and datapath.
// Depends on mrsbt_pkg, mrsbt_ctrl, mrsbt_datapath, mrsbt_modmul.
//
// Usage:
//   Input beat on s_valid/s_ready carries s_witness_base and s_candidate.
//   One result beat on m_valid/m_ready carries m_probable_prime.
//   One item is in flight at a time; s_ready is high only when idle.
//   For candidates below 4 or even the result beat follows in the cycle after
//   accept. Otherwise n-1 is first shifted once per trailing zero, then each
//   modular product runs on the single shift-subtract multiplier: up to
//   2*log2(n) ladder products plus s-1 squarings. At most about 62
//   products at WIDTH=32.
//   The shared multiplier sets the rate.
//   Reset (aresetn low, synchronous) returns to idle and drops any item.
//   A stalled receiver holds the result and m_valid; no new beat is taken
//   until the result is accepted.
module miller_rabin_single_base_test #(
    parameter int WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_witness_base,
    input  logic [31:0] s_candidate,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_probable_prime
);
    mrsbt_pkg::cmd_t    cmd;
    mrsbt_pkg::status_t status;

    mrsbt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    mrsbt_datapath #(.WIDTH(WIDTH)) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_base (s_witness_base[WIDTH-1:0]),
        .in_n    (s_candidate[WIDTH-1:0]),
        .cmd     (cmd),
        .status  (status),
        .result  (m_probable_prime)
    );
endmodule

### tb/tb_miller_rabin_single_base_test.sv
// Testbench for miller_rabin_single_base_test: directed and random strong probable prime checks.
// Depends on the top level and its package; predicts each flag with a local modular exponentiation.
`timescale 1ns / 100ps

module tb_miller_rabin_single_base_test;

    localparam int WIDTH = 32;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 200;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [31:0] s_witness_base;
    logic [31:0] s_candidate;
    logic        m_valid;
    logic        m_ready;
    logic        m_probable_prime;

    bit   expected_flags[$];
    int   error_count = 0;
    int   idle_cycles = 0;
    int   stall_cycles = 0;

    miller_rabin_single_base_test #(.WIDTH(WIDTH)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_witness_base(s_witness_base), .s_candidate(s_candidate),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_probable_prime(m_probable_prime)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    function automatic logic [63:0] mulmod(logic [63:0] x, logic [63:0] y, logic [63:0] n);
        logic [127:0] p;
        p = x * y;
        return 64'(p % n);
    endfunction

    function automatic bit predict_sprp(logic [31:0] a_in, logic [31:0] n_in);
        logic [63:0] a, n, d, acc, x;
        int s;
        a = {32'd0, a_in};
        n = {32'd0, n_in};
        if (n <= 1) return 1'b0;
        if (n <= 3) return 1'b1;
        if (!n[0]) return 1'b0;
        d = n - 1;
        s = 0;
        while (!d[0]) begin
            d = d >> 1;
            s++;
        end
        // base stays unreduced until the first product
        acc = 1;
        while (d > 1) begin
            if (d[0]) acc = mulmod(a, acc, n);
            a = mulmod(a, a, n);
            d = d >> 1;
        end
        x = mulmod(a, acc, n);
        if (x == 1 || x == n - 1) return 1'b1;
        while (s > 1) begin
            x = mulmod(x, x, n);
            if (x == 1) return 1'b0;
            if (x == n - 1) return 1'b1;
            s--;
        end
        return 1'b0;
    endfunction

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // valid stays high across a zero gap; drop it only when idling
    task automatic send_item(logic [31:0] base, logic [31:0] n);
        int gap;
        gap = gap_length();
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_witness_base <= base;
        s_candidate    <= n;
        s_valid        <= 1'b1;
        expected_flags.push_back(predict_sprp(base, n));
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_flags.size() != 0) @(negedge aclk);
    endtask

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_flags.size() == 0) begin
                $display("%0t: unexpected result beat, actual %0b", $realtime, m_probable_prime);
                error_count++;
            end else begin
                if (m_probable_prime !== expected_flags[0]) begin
                    $display("%0t: probable_prime mismatch, expected %0b actual %0b",
                             $realtime, expected_flags[0], m_probable_prime);
                    error_count++;
                end
                void'(expected_flags.pop_front());
            end
        end
    end

    // receiver stalls: mostly short, now and then a long one
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_cycles = 0;
        end else if (stall_cycles > 0) begin
            m_ready <= 1'b0;
            stall_cycles--;
        end else if ($urandom_range(0, 99) < 70) begin
            m_ready <= 1'b1;
        end else if ($urandom_range(0, 19) == 0) begin
            m_ready <= 1'b0;
            stall_cycles = $urandom_range(10, 60);
        end else begin
            m_ready <= 1'b0;
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic logic [31:0] random_odd_candidate();
        int r;
        r = $urandom_range(0, 3);
        case (r)
            0: return $urandom_range(5, 255) | 32'd1;
            1: return $urandom_range(5, 65535) | 32'd1;
            default: return $urandom() | 32'd1;
        endcase
    endfunction

    task automatic test_special_candidates();
        send_item(32'd2, 32'd0);
        send_item(32'd7, 32'd1);
        send_item(32'd0, 32'd2);
        send_item(32'hFFFF_FFFF, 32'd3);
        send_item(32'd3, 32'd4);
        send_item(32'h1234_5678, 32'hFFFF_FFFE);
        send_item(32'd0, 32'd13);
        send_item(32'd26, 32'd13);
    endtask

    task automatic test_directed_values();
        send_item(32'd2, 32'd5);
        send_item(32'd2, 32'd2047);
        send_item(32'd2, 32'd561);
        send_item(32'd2, 32'd3215031751);
        send_item(32'd7, 32'd3215031751);
        send_item(32'd2, 32'd4294967291);
        send_item(32'hFFFF_FFFF, 32'd4294967291);
        send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(32'd4294967290, 32'd4294967291);
        send_item(32'd1, 32'd65537);
        send_item(32'h8000_0000, 32'd97);
        send_item(32'd5, 32'h8000_0001);
        send_item(32'd3, 32'd25);
    endtask

    task automatic test_pause_until_drained();
        send_item(32'd2, 32'd1000003);
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge aclk);
        send_item(32'd3, 32'd1000003);
    endtask

    task automatic test_random_items(int count);
        logic [31:0] base, n;
        for (int i = 0; i < count; i++) begin
            base = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom();
            if ($urandom_range(0, 9) == 0) n = $urandom();
            else n = random_odd_candidate();
            send_item(base, n);
        end
    endtask

    initial begin
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_witness_base = '0;
        s_candidate    = '0;
        repeat (7) @(negedge aclk);
        aresetn = 1'b1;

        test_special_candidates();
        test_directed_values();
        test_pause_until_drained();
        test_random_items(1225);

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (error_count == 0 && expected_flags.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

### miller_rabin_single_base_test.f
+incdir+sv
sv/mrsbt_pkg.sv
sv/mrsbt_modmul.sv
sv/mrsbt_datapath.sv
sv/mrsbt_ctrl.sv
sv/miller_rabin_single_base_test.sv
tb/tb_miller_rabin_single_base_test.sv
